FILE: design/assert_macros.svh
//------------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/mfsp_pkg.sv
//------------------------------------------------------------------------------
// mfsp_pkg
// Shared constants and types of the five-stage pipeline.
//------------------------------------------------------------------------------
package mfsp_pkg;

    localparam int INSTR_WORDS_DEF = 1024;
    localparam int DATA_WORDS_DEF  = 1024;
    localparam int REG_COUNT       = 32;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

endpackage

FILE: design/mfsp_imem.sv
//------------------------------------------------------------------------------
// mfsp_imem
// Instruction store: one write port, two registered read ports, write-first.
//------------------------------------------------------------------------------
module mfsp_imem #(
    parameter int WORDS = mfsp_pkg::INSTR_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic [$clog2(WORDS)-1:0] raddr0,
    input  logic [$clog2(WORDS)-1:0] raddr1,
    output logic [31:0]              rdata0,
    output logic [31:0]              rdata1
);
    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
        rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
    end

endmodule

FILE: design/mfsp_dmem.sv
//------------------------------------------------------------------------------
// mfsp_dmem
// Data store with a clearing sweep after reset and a registered read port.
//------------------------------------------------------------------------------
module mfsp_dmem #(
    parameter int WORDS = mfsp_pkg::DATA_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [31:0]              wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [31:0]              rdata,
    output logic                     busy
);
    localparam int AW = $clog2(WORDS);

    logic [31:0]   mem [WORDS];
    logic          busy_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          we_eff;
    logic [AW-1:0] waddr_eff;
    logic [31:0]   wdata_eff;

    assign busy      = busy_reg;
    assign we_eff    = busy_reg || we;
    assign waddr_eff = busy_reg ? clr_cnt_reg : waddr;
    assign wdata_eff = busy_reg ? 32'h0 : wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(WORDS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_eff)
        begin
            mem[waddr_eff] <= wdata_eff;
        end
        rdata <= (we_eff && waddr_eff == raddr) ? wdata_eff : mem[raddr];
    end

endmodule

FILE: design/mfsp_regfile.sv
//------------------------------------------------------------------------------
// mfsp_regfile
// Even and odd register banks: two reads and one write per bank a cycle.
//------------------------------------------------------------------------------
module mfsp_regfile (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfsp_pkg::rf_wr_t     wr0,
    input  mfsp_pkg::rf_wr_t     wr1,
    input  logic [4:0]           raddr_a,
    input  logic [4:0]           raddr_b,
    output logic [31:0]          rdata_a,
    output logic [31:0]          rdata_b
);
    import mfsp_pkg::*;

    logic [31:0]          mem_even [16];
    logic [31:0]          mem_odd  [16];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]          q_a_reg, q_b_reg;
    logic                 ok_a_reg, ok_b_reg;
    rf_wr_t               we_even, we_odd;
    logic                 hit_a, hit_b;
    logic [31:0]          hit_a_data, hit_b_data;

    always_comb
    begin
        we_even = '0;
        we_odd  = '0;
        if (wr0.en && !wr0.idx[0]) we_even = wr0;
        if (wr1.en && !wr1.idx[0]) we_even = wr1;
        if (wr0.en && wr0.idx[0])  we_odd  = wr0;
        if (wr1.en && wr1.idx[0])  we_odd  = wr1;
        hit_a      = (wr0.en && wr0.idx == raddr_a) || (wr1.en && wr1.idx == raddr_a);
        hit_b      = (wr0.en && wr0.idx == raddr_b) || (wr1.en && wr1.idx == raddr_b);
        hit_a_data = (wr0.en && wr0.idx == raddr_a) ? wr0.data : wr1.data;
        hit_b_data = (wr0.en && wr0.idx == raddr_b) ? wr0.data : wr1.data;
    end

    always_ff @(posedge clk)
    begin
        if (we_even.en)
        begin
            mem_even[we_even.idx[4:1]] <= we_even.data;
        end
        if (we_odd.en)
        begin
            mem_odd[we_odd.idx[4:1]] <= we_odd.data;
        end
        q_a_reg <= hit_a ? hit_a_data
                 : (raddr_a[0] ? mem_odd[raddr_a[4:1]] : mem_even[raddr_a[4:1]]);
        q_b_reg <= hit_b ? hit_b_data
                 : (raddr_b[0] ? mem_odd[raddr_b[4:1]] : mem_even[raddr_b[4:1]]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok_a_reg  <= 1'b0;
            ok_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr0.en) valid_reg[wr0.idx] <= 1'b1;
            if (wr1.en) valid_reg[wr1.idx] <= 1'b1;
            ok_a_reg <= valid_reg[raddr_a] || hit_a;
            ok_b_reg <= valid_reg[raddr_b] || hit_b;
        end
    end

    assign rdata_a = ok_a_reg ? q_a_reg : 32'h0;
    assign rdata_b = ok_b_reg ? q_b_reg : 32'h0;

endmodule

FILE: design/mips_five_stage_pipeline_top.sv
//------------------------------------------------------------------------------
// mips_five_stage_pipeline_top
// Five-stage MIPS subset pipeline driven by a command stream.
//
// Each input transfer is a command: a clock tick of the pipeline, a load of an
// instruction or data word, or a register read. Tick and load commands are
// taken one per clock while s_tready is high, and each gives one result
// transfer; a register read holds off the next command while its value is
// read, as the register bank read port is shared with decode. Instruction
// store, data store and register banks are synchronous memories addressed
// from the next pipeline state. After reset the data store is cleared word
// by word, during which no command is taken (configuration writes still
// are). Results pass through a two-entry output queue.
//------------------------------------------------------------------------------
module mips_five_stage_pipeline_top #(
    parameter int INSTR_WORDS = mfsp_pkg::INSTR_WORDS_DEF,
    parameter int DATA_WORDS  = mfsp_pkg::DATA_WORDS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // command[1:0], word_index[11:2], word_value[43:12]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // retired, retired_pc, reg_written, reg_index,
                                    // reg_value, pair_written, pair_value, finished,
                                    // fetch_stalled, read_value
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mfsp_pkg::*;

    localparam int IAW = $clog2(INSTR_WORDS);
    localparam int DAW = $clog2(DATA_WORDS);

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LOAD_I = 2'd1;
    localparam logic [1:0] CMD_LOAD_D = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] REG_TEXT_FIRST = 2'd0;
    localparam logic [1:0] REG_TEXT_LAST  = 2'd1;
    localparam logic [1:0] REG_DATA_BASE  = 2'd2;

    localparam logic [9:0] RD_LO = 10'd32;
    localparam logic [9:0] RD_HI = 10'd33;

    localparam logic [5:0] OP_R     = 6'd0;
    localparam logic [5:0] OP_BEQ   = 6'd4;
    localparam logic [5:0] OP_ADDI  = 6'd8;
    localparam logic [5:0] OP_SLTI  = 6'd10;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_ANDI  = 6'd12;
    localparam logic [5:0] OP_ORI   = 6'd13;
    localparam logic [5:0] OP_LUI   = 6'd15;
    localparam logic [5:0] OP_LW    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd43;
    localparam logic [5:0] FN_SLL   = 6'd0;
    localparam logic [5:0] FN_SRL   = 6'd2;
    localparam logic [5:0] FN_MULT  = 6'd24;
    localparam logic [5:0] FN_MUL   = 6'd28;
    localparam logic [5:0] FN_ADD   = 6'd32;
    localparam logic [5:0] FN_SUB   = 6'd34;
    localparam logic [5:0] FN_AND   = 6'd36;
    localparam logic [5:0] FN_OR    = 6'd37;

    typedef struct packed {
        logic        valid;
        logic [31:0] ir;
        logic [31:0] ipc;
        logic [31:0] npc;
    } fd_lat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ir;
        logic [31:0] ipc;
        logic [31:0] npc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [4:0]  wreg;
    } de_lat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ir;
        logic [31:0] ipc;
        logic [31:0] b;
        logic [4:0]  wreg;
        logic [63:0] alu;
        logic        cond;
    } em_lat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ir;
        logic [31:0] ipc;
        logic [31:0] lmd;
        logic [4:0]  wreg;
        logic [63:0] alu;
    } mw_lat_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        fetch_stalled;
        logic        finished;
        logic [31:0] pair_value;
        logic        pair_written;
        logic [31:0] reg_value;
        logic [4:0]  reg_index;
        logic        reg_written;
        logic [31:0] retired_pc;
        logic        retired;
    } result_t;

    function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] raw,
                                        input rf_wr_t w0, input rf_wr_t w1);
        logic [31:0] v;
        v = raw;
        if (w1.en && w1.idx == idx) v = w1.data;
        if (w0.en && w0.idx == idx) v = w0.data;
        return v;
    endfunction

    // pipeline state
    fd_lat_t     fd_reg, fd_next, fd_s;
    de_lat_t     de_reg, de_next, de_s;
    em_lat_t     em_reg, em_next, em_s;
    mw_lat_t     mw_reg, mw_next, mw_s;
    logic [31:0] fetch_reg, fetch_next, fetch_s;
    logic        bp_reg, bp_next, bp_s;
    logic [31:0] lo_reg, lo_next, lo_s;
    logic [31:0] hi_reg, hi_next, hi_s;
    logic [31:0] text_first_reg, text_first_next;
    logic [31:0] text_last_reg, text_last_next;
    logic [31:0] data_base_reg, data_base_next;

    // stream and queue
    logic [1:0]  cmd;
    logic [9:0]  widx;
    logic [31:0] wval;
    logic        accept, tick, cfg_wr;
    logic        rd_pend_reg;
    logic [9:0]  rd_idx_reg;
    result_t     fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;
    result_t     tick_res, push_res, read_res;

    // memory ports
    logic [31:0]        im_q0, im_q1, dm_q, rf_a, rf_b;
    logic               im_ok0_reg, im_ok1_reg, dm_ok_reg;
    logic [DAW-1:0]     dm_idx_reg;
    logic [31:0]        im_off0, im_off1, dm_off, tgt_next;
    logic               im_ok0, im_ok1, dm_ok;
    logic               im_we, dm_we, dm_sw;
    logic [DAW-1:0]     dm_waddr;
    logic [31:0]        dm_wdata;
    logic               dmem_busy;
    rf_wr_t             wr0, wr1, rf_wr0, rf_wr1;
    logic [4:0]         rf_raddr_a;
    logic signed [63:0] mul_p;
    logic               hz;

    assign cmd    = s_tdata[1:0];
    assign widx   = s_tdata[11:2];
    assign wval   = s_tdata[43:12];
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign s_tready = !dmem_busy && !rd_pend_reg && (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (cmd == CMD_TICK);

    assign mul_p = $signed(de_reg.a) * $signed(de_reg.b);

    always_comb
    begin : stage_logic
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  sh;
        logic [31:0] r;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] fa;
        logic        set_bp;
        logic        redirect;
        logic        held;

        // writeback
        tick_res = '0;
        wr0      = '0;
        wr1      = '0;
        lo_s     = lo_reg;
        hi_s     = hi_reg;
        op       = mw_reg.ir[31:26];
        fn       = mw_reg.ir[5:0];
        if (mw_reg.valid)
        begin
            tick_res.retired    = 1'b1;
            tick_res.retired_pc = mw_reg.ipc;
            tick_res.finished   = (mw_reg.ipc == text_last_reg);
            if (op == OP_R)
            begin
                case (fn)
                    FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLL, FN_SRL:
                    begin
                        wr0 = '{en: mw_reg.wreg != 5'd0, idx: mw_reg.wreg,
                                data: mw_reg.alu[31:0]};
                    end
                    FN_MUL:
                    begin
                        wr0 = '{en: mw_reg.wreg != 5'd0, idx: mw_reg.wreg,
                                data: mw_reg.alu[31:0]};
                        tick_res.reg_index = mw_reg.wreg;
                        if (mw_reg.wreg != 5'd31)
                        begin
                            wr1 = '{en: 1'b1, idx: mw_reg.wreg + 5'd1,
                                    data: mw_reg.alu[63:32]};
                            tick_res.pair_written = 1'b1;
                            tick_res.pair_value   = mw_reg.alu[63:32];
                        end
                    end
                    FN_MULT:
                    begin
                        lo_s = mw_reg.alu[31:0];
                        hi_s = mw_reg.alu[63:32];
                    end
                    default:
                    begin
                        wr0 = '0;
                    end
                endcase
            end
            else if (op inside {OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_SLTIU, OP_LUI})
            begin
                wr0 = '{en: mw_reg.wreg != 5'd0, idx: mw_reg.wreg, data: mw_reg.alu[31:0]};
            end
            else if (op == OP_LW)
            begin
                wr0 = '{en: mw_reg.wreg != 5'd0, idx: mw_reg.wreg, data: mw_reg.lmd};
            end
            if (wr0.en)
            begin
                tick_res.reg_written = 1'b1;
                tick_res.reg_index   = wr0.idx;
                tick_res.reg_value   = wr0.data;
            end
        end

        // memory
        mw_s  = '0;
        dm_sw = 1'b0;
        op    = em_reg.ir[31:26];
        if (em_reg.valid)
        begin
            mw_s.valid = 1'b1;
            mw_s.ir    = em_reg.ir;
            mw_s.ipc   = em_reg.ipc;
            if (op inside {OP_R, OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_SLTIU, OP_LUI})
            begin
                mw_s.alu  = em_reg.alu;
                mw_s.wreg = em_reg.wreg;
            end
            else if (op == OP_SW)
            begin
                dm_sw = dm_ok_reg;
            end
            else if (op == OP_LW)
            begin
                mw_s.lmd  = dm_ok_reg ? dm_q : 32'h0;
                mw_s.wreg = em_reg.wreg;
            end
        end

        // execute
        em_s = '0;
        op   = de_reg.ir[31:26];
        fn   = de_reg.ir[5:0];
        sh   = de_reg.ir[10:6];
        r    = 32'h0;
        if (de_reg.valid)
        begin
            em_s.valid = 1'b1;
            em_s.ir    = de_reg.ir;
            em_s.ipc   = de_reg.ipc;
            em_s.b     = de_reg.b;
            em_s.wreg  = de_reg.wreg;
            case (op)
                OP_R:
                begin
                    case (fn)
                        FN_ADD:  r = de_reg.a + de_reg.b;
                        FN_SUB:  r = de_reg.a - de_reg.b;
                        FN_AND:  r = de_reg.a & de_reg.b;
                        FN_OR:   r = de_reg.a | de_reg.b;
                        FN_SLL:  r = de_reg.b << sh;
                        FN_SRL:  r = de_reg.b >> sh;
                        default: r = 32'h0;
                    endcase
                    em_s.alu = (fn == FN_MUL || fn == FN_MULT) ? 64'(mul_p) : {32'h0, r};
                end
                OP_ADDI, OP_LW, OP_SW:
                    em_s.alu = {32'h0, de_reg.a + de_reg.imm};
                OP_ANDI:
                    em_s.alu = {32'h0, de_reg.a & {16'h0, de_reg.imm[15:0]}};
                OP_ORI:
                    em_s.alu = {32'h0, de_reg.a | {16'h0, de_reg.imm[15:0]}};
                OP_LUI:
                    em_s.alu = {32'h0, de_reg.imm[15:0], 16'h0};
                OP_SLTI:
                    em_s.alu = {63'h0, $signed(de_reg.a) < $signed(de_reg.imm)};
                OP_SLTIU:
                    em_s.alu = {63'h0, de_reg.a < de_reg.imm};
                OP_BEQ:
                begin
                    em_s.alu  = {32'h0, de_reg.npc + {de_reg.imm[29:0], 2'b00}};
                    em_s.cond = (de_reg.a == de_reg.b);
                end
                default:
                    em_s.alu = 64'h0;
            endcase
        end

        // decode
        de_s   = '0;
        hz     = 1'b0;
        set_bp = 1'b0;
        rs     = fd_reg.ir[25:21];
        rt     = fd_reg.ir[20:16];
        op     = fd_reg.ir[31:26];
        if (fd_reg.valid)
        begin
            if ((em_s.wreg != 5'd0 && (em_s.wreg == rs || em_s.wreg == rt)) ||
                (mw_s.wreg != 5'd0 && (mw_s.wreg == rs || mw_s.wreg == rt)))
            begin
                hz = 1'b1;
            end
            else
            begin
                set_bp     = (op == OP_BEQ);
                de_s.valid = 1'b1;
                de_s.ir    = fd_reg.ir;
                de_s.ipc   = fd_reg.ipc;
                de_s.npc   = fd_reg.npc;
                de_s.a     = fwd(rs, rf_a, wr0, wr1);
                de_s.b     = fwd(rt, rf_b, wr0, wr1);
                if (op == OP_R)
                begin
                    de_s.wreg = fd_reg.ir[15:11];
                end
                else
                begin
                    de_s.imm  = {{16{fd_reg.ir[15]}}, fd_reg.ir[15:0]};
                    de_s.wreg = rt;
                end
            end
        end

        // fetch
        fa       = fetch_reg;
        bp_s     = bp_reg || set_bp;
        fd_s     = fd_reg;
        redirect = 1'b0;
        held     = 1'b0;
        tick_res.fetch_stalled = 1'b0;
        if (bp_s)
        begin
            if (em_s.valid && em_s.ir[31:26] == OP_BEQ)
            begin
                if (em_s.cond)
                begin
                    fa       = em_s.alu[31:0];
                    redirect = 1'b1;
                end
                bp_s = 1'b0;
            end
            else
            begin
                fd_s = '0;
                held = 1'b1;
                tick_res.fetch_stalled = 1'b1;
            end
        end
        if (!held)
        begin
            if (hz)
            begin
                tick_res.fetch_stalled = 1'b1;
            end
            else if (fa > text_last_reg)
            begin
                fd_s = '0;
                tick_res.fetch_stalled = 1'b1;
            end
            else
            begin
                fd_s.valid = 1'b1;
                fd_s.ipc   = fa;
                fd_s.ir    = redirect ? (im_ok1_reg ? im_q1 : 32'h0)
                                      : (im_ok0_reg ? im_q0 : 32'h0);
                fa         = fa + 32'd4;
                fd_s.npc   = fa;
            end
        end
        fetch_s = fa;
    end

    // next state
    always_comb
    begin
        fd_next = tick ? fd_s : fd_reg;
        de_next = tick ? de_s : de_reg;
        em_next = tick ? em_s : em_reg;
        mw_next = tick ? mw_s : mw_reg;
        bp_next = tick ? bp_s : bp_reg;
        lo_next = tick ? lo_s : lo_reg;
        hi_next = tick ? hi_s : hi_reg;
        text_first_next = (cfg_wr && paddr[3:2] == REG_TEXT_FIRST) ? pwdata : text_first_reg;
        text_last_next  = (cfg_wr && paddr[3:2] == REG_TEXT_LAST)  ? pwdata : text_last_reg;
        data_base_next  = (cfg_wr && paddr[3:2] == REG_DATA_BASE)  ? pwdata : data_base_reg;
        if (cfg_wr && paddr[3:2] == REG_TEXT_FIRST)
            fetch_next = pwdata;
        else if (tick)
            fetch_next = fetch_s;
        else
            fetch_next = fetch_reg;
    end

    // read addresses for the next cycle
    assign im_off0  = fetch_next - text_first_next;
    assign tgt_next = de_next.npc + {de_next.imm[29:0], 2'b00};
    assign im_off1  = tgt_next - text_first_next;
    assign dm_off   = em_next.alu[31:0] - data_base_next;
    assign im_ok0   = {2'b00, im_off0[31:2]} < 32'(INSTR_WORDS);
    assign im_ok1   = {2'b00, im_off1[31:2]} < 32'(INSTR_WORDS);
    assign dm_ok    = {2'b00, dm_off[31:2]} < 32'(DATA_WORDS);

    assign im_we    = accept && cmd == CMD_LOAD_I && ({22'h0, widx} < 32'(INSTR_WORDS));
    assign dm_we    = (tick && dm_sw) ||
                      (accept && cmd == CMD_LOAD_D && ({22'h0, widx} < 32'(DATA_WORDS)));
    assign dm_waddr = tick ? dm_idx_reg : DAW'(widx);
    assign dm_wdata = tick ? em_reg.b : wval;

    assign rf_wr0     = tick ? wr0 : '0;
    assign rf_wr1     = tick ? wr1 : '0;
    assign rf_raddr_a = (accept && cmd == CMD_READ) ? widx[4:0] : fd_next.ir[25:21];

    mfsp_imem #(.WORDS(INSTR_WORDS)) u_imem (
        .clk    (clk),
        .we     (im_we),
        .waddr  (IAW'(widx)),
        .wdata  (wval),
        .raddr0 (im_off0[IAW+1:2]),
        .raddr1 (im_off1[IAW+1:2]),
        .rdata0 (im_q0),
        .rdata1 (im_q1)
    );

    mfsp_dmem #(.WORDS(DATA_WORDS)) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (dm_off[DAW+1:2]),
        .rdata (dm_q),
        .busy  (dmem_busy)
    );

    mfsp_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr0     (rf_wr0),
        .wr1     (rf_wr1),
        .raddr_a (rf_raddr_a),
        .raddr_b (fd_next.ir[20:16]),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    // results
    always_comb
    begin
        read_res = '0;
        if (rd_idx_reg < 10'd32)
            read_res.read_value = rf_a;
        else if (rd_idx_reg == RD_LO)
            read_res.read_value = lo_reg;
        else if (rd_idx_reg == RD_HI)
            read_res.read_value = hi_reg;
        push     = (accept && cmd != CMD_READ) || rd_pend_reg;
        push_res = rd_pend_reg ? read_res : (tick ? tick_res : '0);
    end

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {6'h0, fifo_reg[rd_ptr_reg]};

    always_comb
    begin
        case (paddr[3:2])
            REG_TEXT_FIRST: prdata = text_first_reg;
            REG_TEXT_LAST:  prdata = text_last_reg;
            REG_DATA_BASE:  prdata = data_base_reg;
            default:        prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg         <= '0;
            de_reg         <= '0;
            em_reg         <= '0;
            mw_reg         <= '0;
            fetch_reg      <= '0;
            bp_reg         <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            text_first_reg <= '0;
            text_last_reg  <= '0;
            data_base_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
            im_ok0_reg     <= 1'b0;
            im_ok1_reg     <= 1'b0;
            dm_ok_reg      <= 1'b0;
        end
        else
        begin
            fd_reg         <= fd_next;
            de_reg         <= de_next;
            em_reg         <= em_next;
            mw_reg         <= mw_next;
            fetch_reg      <= fetch_next;
            bp_reg         <= bp_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            text_first_reg <= text_first_next;
            text_last_reg  <= text_last_next;
            data_base_reg  <= data_base_next;
            rd_pend_reg    <= accept && cmd == CMD_READ;
            im_ok0_reg     <= im_ok0;
            im_ok1_reg     <= im_ok1;
            dm_ok_reg      <= dm_ok;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        dm_idx_reg <= dm_off[DAW+1:2];
        if (accept)
            rd_idx_reg <= widx;
        if (push)
            fifo_reg[wr_ptr_reg] <= push_res;
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_clear_blocks_input, dmem_busy, !s_tready, "transfer taken during clear")
    `ASSERT_IMPL(a_read_blocks_input, rd_pend_reg, !s_tready, "transfer taken during read")
    `ASSERT_NEVER(a_queue_overflow, (cnt_reg == 2'd2) && push && !pop, "output queue overflow")
    `ASSERT_IMPL(a_branch_bubbles_fetch, bp_reg, !fd_reg.valid, "fetch ran past open branch")

endmodule

FILE: test/mips_five_stage_pipeline_top_test.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// mips_five_stage_pipeline_top_test
// Self-checking bench for the five-stage pipeline. A driver feeds command
// transfers from a queue, and an in-bench pipeline predictor computes the
// result of each one. A monitor compares every result transfer field by field.
// Phases reprogram the address registers over APB, idling varies across phases,
// and one phase holds the result side off long enough to back up the input.
//------------------------------------------------------------------------------
module mips_five_stage_pipeline_top_test;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_LOAD_INSTR = 2'd1,
        CMD_LOAD_DATA  = 2'd2,
        CMD_READ_REG   = 2'd3
    } cmd_e;

    typedef enum logic [5:0] {
        OPC_R = 6'd0, OPC_BEQ = 6'd4, OPC_ADDI = 6'd8, OPC_SLTI = 6'd10,
        OPC_SLTIU = 6'd11, OPC_ANDI = 6'd12, OPC_ORI = 6'd13, OPC_LUI = 6'd15,
        OPC_LW = 6'd35, OPC_SW = 6'd43
    } opc_e;

    typedef enum logic [5:0] {
        FN_SLL = 6'd0, FN_SRL = 6'd2, FN_MULT = 6'd24, FN_MUL = 6'd28,
        FN_ADD = 6'd32, FN_SUB = 6'd34, FN_AND = 6'd36, FN_OR = 6'd37
    } fn_e;

    typedef enum int {
        REG_TEXT_FIRST = 0,
        REG_TEXT_LAST  = 1,
        REG_DATA_BASE  = 2
    } reg_e;

    localparam int  IWORDS        = mfsp_pkg::INSTR_WORDS_DEF;
    localparam int  DWORDS        = mfsp_pkg::DATA_WORDS_DEF;
    localparam int  NREGS         = mfsp_pkg::REG_COUNT;
    localparam int  CYCLE_MAX     = 400000;
    localparam int  HOLD_LEN      = 300;
    localparam int  SETTLE        = 20;
    localparam int  PRELOAD_WORDS = 256;
    localparam int  PHASE_ITEMS   = 65;

    typedef struct {
        cmd_e        cmd;
        logic [9:0]  idx;
        logic [31:0] val;
    } command_t;

    typedef struct {
        logic        retired;
        logic [31:0] retired_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        pair_written;
        logic [31:0] pair_value;
        logic        finished;
        logic        fetch_stalled;
        logic [31:0] read_value;
    } outcome_t;

    typedef struct { bit valid; logic [31:0] ir, ipc, npc; } fd_t;
    typedef struct { bit valid; logic [31:0] ir, ipc, npc, a, b, imm, wreg; } de_t;
    typedef struct { bit valid; logic [31:0] ir, ipc, b, wreg; logic [63:0] alu; bit cond; } em_t;
    typedef struct { bit valid; logic [31:0] ir, ipc, lmd, wreg; logic [63:0] alu; } mw_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    mips_five_stage_pipeline_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    command_t pending_cmds[$];
    outcome_t expected_outcomes[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       hold_go = 1'b0;
    bit       hold_done = 1'b0;
    int       hold_left = 0;

    // pipeline predictor state
    logic [31:0] text_first, text_last, data_base;
    logic [31:0] gpr [NREGS];
    logic [31:0] lo_reg, hi_reg, pc_next;
    fd_t         if_id;
    de_t         id_ex;
    em_t         ex_mem;
    mw_t         mem_wb;
    bit          beq_pending;
    logic [31:0] imem [IWORDS];
    logic [31:0] dmem [DWORDS];

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void wr_gpr(input logic [31:0] i, input logic [31:0] v,
                                   inout outcome_t r);
        if (i == 0 || i >= NREGS)
            return;
        gpr[i] = v;
        r.reg_written = 1'b1;
        r.reg_index = i[4:0];
        r.reg_value = v;
    endfunction

    function automatic outcome_t pipeline_tick();
        outcome_t    r;
        mw_t         nm;
        em_t         ne;
        de_t         nd;
        logic [5:0]  op;
        logic [31:0] ix, rs, rt, w1, w2, lo, hi, rd, rv;
        logic [4:0]  sh;
        logic [63:0] alu;
        bit          hz;
        r = '{default: '0};
        // writeback
        if (mem_wb.valid)
        begin
            r.retired = 1'b1;
            r.retired_pc = mem_wb.ipc;
            r.finished = (mem_wb.ipc == text_last);
            op = mem_wb.ir[31:26];
            lo = mem_wb.alu[31:0];
            hi = mem_wb.alu[63:32];
            if (op == OPC_R)
            begin
                case (mem_wb.ir[5:0])
                    FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLL, FN_SRL: wr_gpr(mem_wb.wreg, lo, r);
                    FN_MUL:
                    begin
                        rd = mem_wb.wreg & 32'h1F;
                        wr_gpr(rd, lo, r);
                        r.reg_index = rd[4:0];
                        if (rd + 1 < NREGS)
                        begin
                            gpr[rd + 1] = hi;
                            r.pair_written = 1'b1;
                            r.pair_value = hi;
                        end
                    end
                    FN_MULT:
                    begin
                        lo_reg = lo;
                        hi_reg = hi;
                    end
                    default: ;
                endcase
            end
            else if (op inside {OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_SLTI, OPC_SLTIU, OPC_LUI})
                wr_gpr(mem_wb.wreg, lo, r);
            else if (op == OPC_LW)
                wr_gpr(mem_wb.wreg, mem_wb.lmd, r);
        end
        // memory
        nm = '{default: '0};
        if (ex_mem.valid)
        begin
            nm.valid = 1'b1;
            nm.ir = ex_mem.ir;
            nm.ipc = ex_mem.ipc;
            op = ex_mem.ir[31:26];
            ix = (ex_mem.alu[31:0] - data_base) >> 2;
            if (op inside {OPC_R, OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_SLTI, OPC_SLTIU, OPC_LUI})
            begin
                nm.alu = ex_mem.alu;
                nm.wreg = ex_mem.wreg;
            end
            else if (op == OPC_SW)
            begin
                if (ix < DWORDS)
                    dmem[ix] = ex_mem.b;
            end
            else if (op == OPC_LW)
            begin
                nm.lmd = (ix < DWORDS) ? dmem[ix] : 32'd0;
                nm.wreg = ex_mem.wreg;
            end
        end
        mem_wb = nm;
        // execute
        ne = '{default: '0};
        if (id_ex.valid)
        begin
            ne.valid = 1'b1;
            ne.ir = id_ex.ir;
            ne.ipc = id_ex.ipc;
            ne.b = id_ex.b;
            ne.wreg = id_ex.wreg;
            op = id_ex.ir[31:26];
            sh = id_ex.ir[10:6];
            alu = '0;
            rv = '0;
            case (op)
                OPC_R:
                begin
                    case (id_ex.ir[5:0])
                        FN_ADD: rv = id_ex.a + id_ex.b;
                        FN_SUB: rv = id_ex.a - id_ex.b;
                        FN_AND: rv = id_ex.a & id_ex.b;
                        FN_OR:  rv = id_ex.a | id_ex.b;
                        FN_SLL: rv = id_ex.b << sh;
                        FN_SRL: rv = id_ex.b >> sh;
                        FN_MUL, FN_MULT:
                            alu = longint'($signed(id_ex.a)) * longint'($signed(id_ex.b));
                        default: ;
                    endcase
                    if (alu == 0)
                        alu = {32'd0, rv};
                end
                OPC_ADDI, OPC_LW, OPC_SW: alu = {32'd0, id_ex.a + id_ex.imm};
                OPC_ANDI:  alu = {32'd0, id_ex.a & {16'd0, id_ex.imm[15:0]}};
                OPC_ORI:   alu = {32'd0, id_ex.a | {16'd0, id_ex.imm[15:0]}};
                OPC_LUI:   alu = {32'd0, id_ex.imm[15:0], 16'd0};
                OPC_SLTI:  alu = ($signed(id_ex.a) < $signed(id_ex.imm)) ? 64'd1 : 64'd0;
                OPC_SLTIU: alu = (id_ex.a < id_ex.imm) ? 64'd1 : 64'd0;
                OPC_BEQ:
                begin
                    alu = {32'd0, id_ex.npc + (id_ex.imm << 2)};
                    ne.cond = (id_ex.a == id_ex.b);
                end
                default: ;
            endcase
            ne.alu = alu;
        end
        ex_mem = ne;
        // decode
        nd = '{default: '0};
        hz = 1'b0;
        if (if_id.valid)
        begin
            rs = 32'(if_id.ir[25:21]);
            rt = 32'(if_id.ir[20:16]);
            w1 = ex_mem.wreg;
            w2 = mem_wb.wreg;
            if ((w1 != 0 && (w1 == rs || w1 == rt)) || (w2 != 0 && (w2 == rs || w2 == rt)))
                hz = 1'b1;
            else
            begin
                op = if_id.ir[31:26];
                if (op == OPC_BEQ)
                    beq_pending = 1'b1;
                nd.valid = 1'b1;
                nd.ir = if_id.ir;
                nd.ipc = if_id.ipc;
                nd.npc = if_id.npc;
                nd.a = gpr[rs];
                nd.b = gpr[rt];
                if (op == OPC_R)
                    nd.wreg = 32'(if_id.ir[15:11]);
                else
                begin
                    nd.imm = {{16{if_id.ir[15]}}, if_id.ir[15:0]};
                    nd.wreg = rt;
                end
            end
        end
        id_ex = nd;
        // fetch
        if (beq_pending)
        begin
            if (ex_mem.valid && ex_mem.ir[31:26] == OPC_BEQ)
            begin
                if (ex_mem.cond)
                    pc_next = ex_mem.alu[31:0];
                beq_pending = 1'b0;
            end
            else
            begin
                if_id = '{default: '0};
                r.fetch_stalled = 1'b1;
                return r;
            end
        end
        if (hz)
        begin
            r.fetch_stalled = 1'b1;
            return r;
        end
        if (pc_next > text_last)
        begin
            if_id = '{default: '0};
            r.fetch_stalled = 1'b1;
            return r;
        end
        ix = (pc_next - text_first) >> 2;
        if_id.valid = 1'b1;
        if_id.ipc = pc_next;
        if_id.ir = (ix < IWORDS) ? imem[ix] : 32'd0;
        pc_next = pc_next + 4;
        if_id.npc = pc_next;
        return r;
    endfunction

    function automatic outcome_t predict_outcome(input command_t c);
        outcome_t r;
        r = '{default: '0};
        case (c.cmd)
            CMD_LOAD_INSTR: imem[c.idx] = c.val;
            CMD_LOAD_DATA:  dmem[c.idx] = c.val;
            CMD_READ_REG:
                if (c.idx < NREGS)
                    r.read_value = gpr[c.idx];
                else if (c.idx == 32)
                    r.read_value = lo_reg;
                else if (c.idx == 33)
                    r.read_value = hi_reg;
            default: r = pipeline_tick();
        endcase
        return r;
    endfunction

    // drive commands
    always @(posedge clk)
    begin
        command_t c;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = pending_cmds.pop_front();
                expected_outcomes.push_back(predict_outcome(c));
                s_tdata <= {4'd0, c.val, c.idx, c.cmd};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // check results
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    check_field("retired", e.retired, m_tdata[0]);
                    check_field("retired_pc", e.retired_pc, m_tdata[32:1]);
                    check_field("reg_written", e.reg_written, m_tdata[33]);
                    check_field("reg_index", e.reg_index, m_tdata[38:34]);
                    check_field("reg_value", e.reg_value, m_tdata[70:39]);
                    check_field("pair_written", e.pair_written, m_tdata[71]);
                    check_field("pair_value", e.pair_value, m_tdata[103:72]);
                    check_field("finished", e.finished, m_tdata[104]);
                    check_field("fetch_stalled", e.fetch_stalled, m_tdata[105]);
                    check_field("read_value", e.read_value, m_tdata[137:106]);
                end
            end
            m_tready <= (hold_left == 0 && !(hold_go && !hold_done))
                        && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_cmd(input cmd_e c, input logic [9:0] i, input logic [31:0] v);
        pending_cmds.push_back('{cmd: c, idx: i, val: v});
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input reg_e r, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(4 * r);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_TEXT_FIRST:
            begin
                text_first = v;
                pc_next = v;
            end
            REG_TEXT_LAST: text_last = v;
            default: data_base = v;
        endcase
    endtask

    function automatic logic [31:0] r_word(input int rs, input int rt, input int rd,
                                           input int sh, input fn_e f);
        return {OPC_R, 5'(rs), 5'(rt), 5'(rd), 5'(sh), f};
    endfunction

    function automatic logic [31:0] i_word(input opc_e o, input int rs, input int rt,
                                           input logic [15:0] imm);
        return {o, 5'(rs), 5'(rt), imm};
    endfunction

    function automatic int pick_reg();
        return ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(7);
    endfunction

    function automatic logic [31:0] random_instruction();
        fn_e fns[8] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLL, FN_SRL, FN_MULT, FN_MUL};
        opc_e ops[6] = '{OPC_ADDI, OPC_ANDI, OPC_ORI, OPC_LUI, OPC_SLTI, OPC_SLTIU};
        case ($urandom_range(9))
            0, 1, 2, 3:
                return r_word(pick_reg(), pick_reg(), pick_reg(), $urandom_range(31),
                              fns[$urandom_range(7)]);
            4, 5:
                return i_word(ops[$urandom_range(5)], pick_reg(), pick_reg(),
                              16'($urandom));
            6:
                return i_word(OPC_LW, 0, pick_reg(),
                              ($urandom_range(3) == 0) ? 16'($urandom) : 16'(4 * $urandom_range(15)));
            7:
                return i_word(OPC_SW, 0, pick_reg(),
                              ($urandom_range(3) == 0) ? 16'($urandom) : 16'(4 * $urandom_range(15)));
            8:
                return i_word(OPC_BEQ, pick_reg(), pick_reg(), 16'($signed(-3 + $urandom_range(7))));
            default:
                return $urandom;
        endcase
    endfunction

    task automatic random_traffic(input int n, input int prog_words);
        int k;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(19))
                0, 1:
                    push_cmd(CMD_READ_REG, ($urandom_range(3) == 0) ? 10'($urandom) :
                             10'($urandom_range(35)), $urandom);
                2:
                    push_cmd(CMD_LOAD_DATA, ($urandom_range(1) == 0) ? 10'($urandom) :
                             10'($urandom_range(15)), $urandom);
                3:
                    push_cmd(CMD_LOAD_INSTR, ($urandom_range(3) == 0) ? 10'($urandom) :
                             10'($urandom_range(prog_words - 1)), random_instruction());
                default:
                    push_cmd(CMD_TICK, 10'($urandom), $urandom);
            endcase
        end
    endtask

    initial
    begin
        logic [31:0] firsts[9], lasts[9], bases[9];
        logic [31:0] prog[16];
        int p, k, words;
        text_first = '0;
        text_last = '0;
        data_base = '0;
        lo_reg = '0;
        hi_reg = '0;
        pc_next = '0;
        if_id = '{default: '0};
        id_ex = '{default: '0};
        ex_mem = '{default: '0};
        mem_wb = '{default: '0};
        beq_pending = 1'b0;
        for (k = 0; k < NREGS; k++)
            gpr[k] = '0;
        for (k = 0; k < DWORDS; k++)
            dmem[k] = '0;
        for (k = 0; k < IWORDS; k++)
            imem[k] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        prog = '{
            i_word(OPC_ADDI, 0, 1, 16'h8000),
            i_word(OPC_ORI, 0, 2, 16'hFFFF),
            i_word(OPC_LUI, 0, 3, 16'hFFFF),
            r_word(1, 2, 4, 0, FN_ADD),
            r_word(3, 1, 5, 0, FN_SUB),
            r_word(1, 2, 6, 0, FN_AND),
            r_word(3, 2, 7, 0, FN_OR),
            r_word(0, 3, 8, 31, FN_SRL),
            r_word(0, 2, 9, 31, FN_SLL),
            r_word(1, 3, 0, 0, FN_MULT),
            r_word(1, 1, 31, 0, FN_MUL),
            i_word(OPC_SLTI, 1, 10, 16'h0001),
            i_word(OPC_SLTIU, 2, 11, 16'hFFFF),
            i_word(OPC_SW, 0, 1, 16'h0004),
            i_word(OPC_LW, 0, 12, 16'h0004),
            i_word(OPC_BEQ, 0, 0, 16'hFFF0)
        };
        // load every word that a phase can reach before any fetch
        for (k = 0; k < PRELOAD_WORDS; k++)
            push_cmd(CMD_LOAD_INSTR, 10'(k), (k < 16) ? prog[k] : random_instruction());
        firsts = '{32'd0, 32'd64, 32'hFFFF_FFF0, 32'd0, 32'd256, 32'hFFFF_FFFF,
                   32'd0, 32'd4, 32'd128};
        lasts  = '{32'd60, 32'd188, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd400, 32'd0,
                   32'd124, 32'd84, 32'd252};
        bases  = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'd0, 32'd0,
                   32'd16, 32'd0, 32'hFFFF_FFFC};
        for (p = 0; p < 9; p++)
        begin
            send_idle_pct = (p < 3) ? 10 : (p < 6) ? 61 : 0;
            recv_idle_pct = (p < 3) ? 61 : (p < 6) ? 10 : 0;
            wait_drained();
            apb_write(REG_TEXT_FIRST, firsts[p]);
            apb_write(REG_TEXT_LAST, lasts[p]);
            apb_write(REG_DATA_BASE, bases[p]);
            words = (lasts[p] - firsts[p]) / 4 + 1;
            if (words > IWORDS || words < 1)
                words = IWORDS;
            if (p == 0)
            begin
                for (k = 0; k < 20; k++)
                    push_cmd(CMD_TICK, 10'h3FF, 32'hFFFF_FFFF);
                push_cmd(CMD_READ_REG, 10'd32, '0);
                push_cmd(CMD_READ_REG, 10'd33, '0);
                push_cmd(CMD_READ_REG, 10'd34, '0);
                push_cmd(CMD_READ_REG, 10'h3FF, '0);
                push_cmd(CMD_LOAD_DATA, 10'h3FF, 32'hFFFF_FFFF);
            end
            else
            begin
                if (p == 7)
                    hold_go = 1'b1;
                random_traffic(PHASE_ITEMS, words);
            end
        end
        wait_drained();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
